@@ design/hbs_pkg.sv @@
// Shared types and constants of the height-map bilinear sampler.
// Used by every module in this folder but hbs_ram; depends on nothing.
package hbs_pkg;

	// Field widths fixed by the stream formats
	localparam int SIDE_W    = 9;   // grid side register and cell coordinates
	localparam int SPACING_W = 31;  // unsigned Q15.16 cell spacing
	localparam int POS_W     = 32;  // signed Q16.16 position
	localparam int HGT_W     = 32;  // signed Q16.16 height on the streams
	localparam int FRAC_W    = 16;  // fraction bits of a grid coordinate
	localparam int QUOT_W    = SIDE_W + FRAC_W;        // grid coordinate bits
	localparam int EXT_W     = SIDE_W + SPACING_W;     // world extent bits
	localparam int IN_W      = 112;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;

	// Defaults of the top level parameters
	localparam int MAX_SIDE_DEF    = 256;
	localparam int HEIGHT_BITS_DEF = 32;

	// Smallest usable spacing, about one millimetre
	localparam logic [SPACING_W-1:0] MIN_SPACING = 31'd66;
	localparam logic [SIDE_W-1:0]    SIDE_MIN    = 9'd2;

	// Register reset values
	localparam logic [SIDE_W-1:0]    GRID_WIDTH_RST   = 9'd256;
	localparam logic [SIDE_W-1:0]    GRID_LENGTH_RST  = 9'd256;
	localparam logic [SPACING_W-1:0] CELL_SPACING_RST = 31'd65536;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_GRID_WIDTH   = 2'd0;
	localparam logic [1:0] REG_GRID_LENGTH  = 2'd1;
	localparam logic [1:0] REG_CELL_SPACING = 2'd2;

	// Item kinds on the slave side
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Result of one axis: floor cell, clamped neighbour, fraction, in-range flag
	typedef struct packed {
		logic [SIDE_W-1:0] i0;
		logic [SIDE_W-1:0] i1;
		logic [FRAC_W-1:0] frac;
		logic              in_range;
	} axis_res_t;

endpackage

@@ design/hbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/hbs_lerp.sv @@
// Bit-serial linear blend y = a + floor((b - a) * t / 2^16).
// Depends on hbs_pkg.
module hbs_lerp import hbs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [HGT_W-1:0] a,
	input  logic signed [HGT_W-1:0] b,
	input  logic [FRAC_W-1:0]       t,
	output logic                    done,
	output logic signed [HGT_W-1:0] y
);

	localparam int CNT_W = $clog2(FRAC_W);

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [HGT_W:0]   d_q;
	logic signed [HGT_W-1:0] a_q;
	logic [FRAC_W-1:0]       t_q;
	logic signed [HGT_W+1:0] acc_q;
	logic signed [HGT_W+1:0] sum;

	// One multiplier bit per cycle; the bit that drops out of the
	// accumulator is below the binary point and is discarded (floor).
	assign sum = acc_q + (t_q[0] ? (HGT_W+2)'(d_q) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(FRAC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			acc_q <= sum >>> 1;
			t_q   <= t_q >> 1;
		end else if (start) begin
			d_q   <= (HGT_W+1)'(b) - (HGT_W+1)'(a);
			a_q   <= a;
			t_q   <= t;
			acc_q <= '0;
		end
	end

	assign done = done_q;
	assign y    = a_q + acc_q[HGT_W-1:0];

endmodule

@@ design/hbs_axis.sv @@
// One axis of a query: extent by serial multiply, clamp, then a
// restoring divide by the cell spacing one quotient bit per cycle. Depends on hbs_pkg.
module hbs_axis import hbs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [POS_W-1:0] pos,
	input  logic [SIDE_W-1:0]       side,
	input  logic [SPACING_W-1:0]    spacing,
	output logic                    done,
	output axis_res_t               res
);

	typedef enum logic [4:0] {
		A_IDLE = 5'b00001,
		A_MUL  = 5'b00010,
		A_CLP  = 5'b00100,
		A_DIV  = 5'b01000,
		A_DONE = 5'b10000
	} ax_state_t;

	localparam int CNT_W = $clog2(QUOT_W);

	ax_state_t               state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [POS_W-1:0] pos_q;
	logic [SIDE_W-1:0]       side_q;
	logic [SPACING_W-1:0]    cs_q;
	logic [EXT_W-1:0]        mcand_q;
	logic [SIDE_W-1:0]       mplier_q;
	logic [EXT_W-1:0]        ext_q;
	logic [SPACING_W-1:0]    rem_q;
	logic [QUOT_W-1:0]       quo_q;
	logic                    inside_q;

	logic                    neg;
	logic                    over;
	logic [SPACING_W-1:0]    pclamp;
	logic [SPACING_W:0]      trial;
	logic                    ge;
	logic [SIDE_W-1:0]       last;
	logic [SIDE_W-1:0]       cell_idx;

	assign neg    = pos_q[POS_W-1];
	assign over   = !neg && (EXT_W'(pos_q[POS_W-2:0]) > ext_q);
	assign pclamp = neg ? '0 : (over ? ext_q[SPACING_W-1:0] : pos_q[POS_W-2:0]);
	assign trial  = {rem_q, quo_q[QUOT_W-1]};
	assign ge     = trial >= {1'b0, cs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				A_IDLE: begin
					if (start) begin
						state_q <= A_MUL;
						cnt_q   <= '0;
					end
				end
				A_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SIDE_W - 1)) begin
						state_q <= A_CLP;
					end
				end
				A_CLP: begin
					state_q <= A_DIV;
					cnt_q   <= '0;
				end
				A_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QUOT_W - 1)) begin
						state_q <= A_DONE;
					end
				end
				A_DONE: begin
					state_q <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: begin
				if (start) begin
					pos_q    <= pos;
					side_q   <= side;
					cs_q     <= spacing;
					mcand_q  <= EXT_W'(spacing);
					mplier_q <= side - 1'b1;
					ext_q    <= '0;
				end
			end
			A_MUL: begin
				if (mplier_q[0]) begin
					ext_q <= ext_q + mcand_q;
				end
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
			A_CLP: begin
				// clamped position < 512 * spacing, so its top bits are
				// already below the divisor
				inside_q <= !neg && !over;
				rem_q    <= SPACING_W'(pclamp[SPACING_W-1:SIDE_W]);
				quo_q    <= {pclamp[SIDE_W-1:0], {FRAC_W{1'b0}}};
			end
			A_DIV: begin
				rem_q <= ge ? SPACING_W'(trial - {1'b0, cs_q}) : trial[SPACING_W-1:0];
				quo_q <= {quo_q[QUOT_W-2:0], ge};
			end
			A_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign last     = side_q - 1'b1;
	assign cell_idx = quo_q[QUOT_W-1:FRAC_W];

	assign done         = (state_q == A_DONE);
	assign res.i0       = (cell_idx > last) ? last : cell_idx;
	assign res.i1       = (cell_idx >= last) ? last : cell_idx + 1'b1;
	assign res.frac     = quo_q[FRAC_W-1:0];
	assign res.in_range = inside_q;

endmodule

@@ design/heightmap_bilinear_sampler_core.sv @@
// Top level of the height-map bilinear sampler: stream ports, APB registers,
// height store, sequencer. Depends on hbs_pkg, hbs_ram, hbs_axis, hbs_lerp.
//
//  channel  | kind            | payload
//  ---------+-----------------+----------------------------------------------------
//  s_       | stream in       | tuser: action; tdata: cell_x, cell_z, sample_height,
//           |                 |        pos_x, pos_z
//  m_       | stream out      | tuser: inside_res; tdata: height
//  p*       | APB registers   | 0x0 grid_width, 0x4 grid_length, 0x8 cell_spacing
//
// A write item is stored at the edge of its transfer.
// A query keeps s_tready low from its transfer until its result is loaded into the output
// register: the two axis units side by side (9-step serial extent multiply, a clamp,
// 25-step restoring divide, a done state), the single RAM read port for the four corners,
// then the one bit-serial blend unit (start, 16 steps, done), which the three blends
// share, and the load of the output register.
// The store needs no clearing after reset; arst_n clears control state only.
// A finished result waits in the output register while the next item is taken;
// a query finishing while that register is still full holds until it empties.
module heightmap_bilinear_sampler_core import hbs_pkg::*; #(
	parameter int MAX_SIDE    = MAX_SIDE_DEF,
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// stream in
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,   // cell_x[7:0], cell_z[15:8], sample_height[47:16],
	                                      // pos_x[79:48], pos_z[111:80]
	input  logic [0:0]         s_tuser,   // action[0]
	// stream out
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [HGT_W-1:0]   m_tdata,   // height[31:0]
	output logic [0:0]         m_tuser,   // inside_res[0]
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W = $clog2(DEPTH);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_AXIS = 5'b00010,
		ST_READ = 5'b00100,
		ST_LERP = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	// configuration
	logic [SIDE_W-1:0]    grid_width_q;
	logic [SIDE_W-1:0]    grid_length_q;
	logic [SPACING_W-1:0] cell_spacing_q;
	logic                 cfg_wr;
	logic [SIDE_W-1:0]    side_x;
	logic [SIDE_W-1:0]    side_z;
	logic [SPACING_W-1:0] spacing;

	// input fields
	logic                    action;
	logic [7:0]              cell_x;
	logic [7:0]              cell_z;
	logic signed [HGT_W-1:0] sample_height;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_z;
	logic                    in_xfer;

	// sequencing
	state_t                  state_q;
	logic [2:0]              rd_cnt_q;
	logic [1:0]              lsel_q;
	logic                    lerp_go_q;
	axis_res_t               res_x_q;
	axis_res_t               res_z_q;
	logic signed [HGT_W-1:0] h00_q;
	logic signed [HGT_W-1:0] h10_q;
	logic signed [HGT_W-1:0] h01_q;
	logic signed [HGT_W-1:0] h11_q;
	logic signed [HGT_W-1:0] h0_q;
	logic signed [HGT_W-1:0] h1_q;
	logic signed [HGT_W-1:0] hres_q;
	logic                    out_load;

	// output register
	logic                    m_tvalid_q;
	logic [HGT_W-1:0]        m_tdata_q;
	logic                    m_tuser_q;

	// axis units
	logic                    ax_start;
	logic                    x_done;
	logic                    z_done;
	axis_res_t               x_res;
	axis_res_t               z_res;

	// store
	logic                    wr_en;
	logic [ADDR_W-1:0]       wr_addr;
	logic [HEIGHT_BITS-1:0]  wr_data;
	logic [ADDR_W-1:0]       rd_addr;
	logic [HEIGHT_BITS-1:0]  rd_data;
	logic signed [63:0]      rd_wide;
	logic signed [HGT_W-1:0] rd_height;
	logic [SIDE_W-1:0]       rx;
	logic [SIDE_W-1:0]       rz;
	logic signed [63:0]      wr_wide;

	// blend unit
	logic signed [HGT_W-1:0] la;
	logic signed [HGT_W-1:0] lb;
	logic [FRAC_W-1:0]       lt;
	logic                    lerp_done;
	logic signed [HGT_W-1:0] lerp_y;

	// ---------------------------------------------------------------- registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q   <= GRID_WIDTH_RST;
			grid_length_q  <= GRID_LENGTH_RST;
			cell_spacing_q <= CELL_SPACING_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_GRID_WIDTH:   grid_width_q   <= pwdata[SIDE_W-1:0];
				REG_GRID_LENGTH:  grid_length_q  <= pwdata[SIDE_W-1:0];
				REG_CELL_SPACING: cell_spacing_q <= pwdata[SPACING_W-1:0];
				default: begin
					// drop writes to unmapped addresses
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_GRID_WIDTH:   prdata = PDATA_W'(grid_width_q);
			REG_GRID_LENGTH:  prdata = PDATA_W'(grid_length_q);
			REG_CELL_SPACING: prdata = PDATA_W'(cell_spacing_q);
			default:          prdata = '0;
		endcase
	end

	// Clamp the sides to [2, MAX_SIDE] and the spacing to its minimum
	always_comb begin
		priority if (32'(grid_width_q) > MAX_SIDE) begin
			side_x = SIDE_W'(MAX_SIDE);
		end else if (grid_width_q < SIDE_MIN) begin
			side_x = SIDE_MIN;
		end else begin
			side_x = grid_width_q;
		end
		priority if (32'(grid_length_q) > MAX_SIDE) begin
			side_z = SIDE_W'(MAX_SIDE);
		end else if (grid_length_q < SIDE_MIN) begin
			side_z = SIDE_MIN;
		end else begin
			side_z = grid_length_q;
		end
	end

	assign spacing = (cell_spacing_q < MIN_SPACING) ? MIN_SPACING : cell_spacing_q;

	// ---------------------------------------------------------------- input side
	assign action        = s_tuser[0];
	assign cell_x        = s_tdata[7:0];
	assign cell_z        = s_tdata[15:8];
	assign sample_height = s_tdata[47:16];
	assign pos_x         = s_tdata[79:48];
	assign pos_z         = s_tdata[111:80];

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign ax_start = in_xfer && (action == ACT_QUERY);

	// Store writes go straight in; drop those outside the store
	assign wr_en   = in_xfer && (action == ACT_WRITE) &&
	                 (32'(cell_x) < MAX_SIDE) && (32'(cell_z) < MAX_SIDE);
	assign wr_addr = ADDR_W'(32'(cell_z) * 32'(MAX_SIDE) + 32'(cell_x));
	assign wr_wide = 64'(sample_height);
	assign wr_data = wr_wide[HEIGHT_BITS-1:0];

	hbs_ram #(
		.WIDTH (HEIGHT_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Narrow stores hold the sample's low bits, sign-extended on read; wide ones keep its low word
	assign rd_wide   = 64'(signed'(rd_data));
	assign rd_height = rd_wide[HGT_W-1:0];

	// ---------------------------------------------------------------- axis units
	hbs_axis u_axis_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ax_start),
		.pos     (pos_x),
		.side    (side_x),
		.spacing (spacing),
		.done    (x_done),
		.res     (x_res)
	);

	hbs_axis u_axis_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ax_start),
		.pos     (pos_z),
		.side    (side_z),
		.spacing (spacing),
		.done    (z_done),
		.res     (z_res)
	);

	// ---------------------------------------------------------------- corner reads
	// Issue the four corners in order; data for issue k lands in the next cycle
	always_comb begin
		unique case (rd_cnt_q)
			3'd0: begin
				rx = res_x_q.i0;
				rz = res_z_q.i0;
			end
			3'd1: begin
				rx = res_x_q.i1;
				rz = res_z_q.i0;
			end
			3'd2: begin
				rx = res_x_q.i0;
				rz = res_z_q.i1;
			end
			3'd3: begin
				rx = res_x_q.i1;
				rz = res_z_q.i1;
			end
			default: begin
				rx = res_x_q.i1;
				rz = res_z_q.i1;
			end
		endcase
	end

	assign rd_addr = ADDR_W'(32'(rz) * 32'(MAX_SIDE) + 32'(rx));

	// ---------------------------------------------------------------- blends
	// Along X on the near row, along X on the far row, then along Z
	always_comb begin
		unique case (lsel_q)
			2'd0: begin
				la = h00_q;
				lb = h10_q;
				lt = res_x_q.frac;
			end
			2'd1: begin
				la = h01_q;
				lb = h11_q;
				lt = res_x_q.frac;
			end
			default: begin
				la = h0_q;
				lb = h1_q;
				lt = res_z_q.frac;
			end
		endcase
	end

	hbs_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lerp_go_q),
		.a      (la),
		.b      (lb),
		.t      (lt),
		.done   (lerp_done),
		.y      (lerp_y)
	);

	// ---------------------------------------------------------------- sequencer
	assign out_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_cnt_q   <= '0;
			lsel_q     <= '0;
			lerp_go_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			lerp_go_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (ax_start) begin
						state_q <= ST_AXIS;
					end
				end
				ST_AXIS: begin
					if (x_done) begin
						state_q  <= ST_READ;
						rd_cnt_q <= '0;
					end
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == 3'd4) begin
						state_q   <= ST_LERP;
						lsel_q    <= 2'd0;
						lerp_go_q <= 1'b1;
					end
				end
				ST_LERP: begin
					if (lerp_done) begin
						if (lsel_q == 2'd2) begin
							state_q <= ST_FIN;
						end else begin
							lsel_q    <= lsel_q + 1'b1;
							lerp_go_q <= 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// hold the result until the far side takes it
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_AXIS && x_done) begin
			res_x_q <= x_res;
			res_z_q <= z_res;
		end
		if (state_q == ST_READ) begin
			unique case (rd_cnt_q)
				3'd1:    h00_q <= rd_height;
				3'd2:    h10_q <= rd_height;
				3'd3:    h01_q <= rd_height;
				3'd4:    h11_q <= rd_height;
				default: begin
				end
			endcase
		end
		if (state_q == ST_LERP && lerp_done) begin
			unique case (lsel_q)
				2'd0:    h0_q   <= lerp_y;
				2'd1:    h1_q   <= lerp_y;
				default: hres_q <= lerp_y;
			endcase
		end
		if (out_load) begin
			m_tdata_q <= hres_q;
			m_tuser_q <= res_x_q.in_range && res_z_q.in_range;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

`ifndef NO_ASSERTIONS
	// Both axis lanes start together and have fixed latency
	a_axes_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		x_done == z_done)
		else $error("axis units finished out of step");

	a_axis_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		x_done |-> (state_q == ST_AXIS))
		else $error("axis result arrived outside the axis phase");

	a_lerp_when_blending: assert property (@(posedge clk) disable iff (!arst_n)
		lerp_done |-> (state_q == ST_LERP))
		else $error("blend result arrived outside the blend phase");

	a_cells_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		x_done |-> (x_res.i0 <= x_res.i1) && (x_res.i1 < side_x) &&
		           (z_res.i0 <= z_res.i1) && (z_res.i1 < side_z))
		else $error("corner cell outside the grid in use");
`endif

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for heightmap_bilinear_sampler_core: stream and APB drivers,
// a bilinear height predictor with its own copy of the store, and a result checker.
// Depends on hbs_pkg and the design sources only.
`timescale 1ns / 100ps

module tb;
	import hbs_pkg::*;

	localparam int          GRID_MAX     = MAX_SIDE_DEF;
	localparam int          DRAIN_CYCLES = 150;      // more than one query's latency
	localparam longint      CYCLE_LIMIT  = 1_000_000;
	localparam logic [1:0]  REG_UNUSED   = 2'd3;     // no register lives here

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata;   // cell_x, cell_z, sample_height, pos_x, pos_z (low bits first)
	logic [0:0]         s_tuser;   // action
	logic               m_tvalid;
	logic               m_tready;
	logic [HGT_W-1:0]   m_tdata;   // height
	logic [0:0]         m_tuser;   // inside_res
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	heightmap_bilinear_sampler_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// One input item; the typed fields hold an expectation written out by hand
	typedef struct {
		logic        act;
		logic [7:0]  cx;
		logic [7:0]  cz;
		logic [31:0] hv;
		logic [31:0] px;
		logic [31:0] pz;
		bit          typed;
		logic [31:0] typed_h;
		logic        typed_in;
	} stim_t;

	typedef struct {
		logic [31:0] hgt;
		logic        in_range;
	} height_res_t;

	typedef struct {
		int unsigned i0;
		int unsigned i1;
		int unsigned frac;
	} cell_split_t;

	typedef longint unsigned u64_t;

	// Shadow of the block: registers as written, height store and its written marks
	logic [8:0]         cfg_width;
	logic [8:0]         cfg_length;
	logic [30:0]        cfg_spacing;
	logic signed [31:0] shadow_heights [0:65535];
	bit                 shadow_written [0:65535];

	height_res_t pending_heights[$];
	int          n_fail;
	int          n_sent;
	bit          s_idle_on;
	bit          m_idle_on;
	longint      cycles;

	function automatic int unsigned side_in_use(logic [8:0] v);
		if (v > 9'(GRID_MAX))
			return GRID_MAX;
		if (v < SIDE_MIN)
			return int'(SIDE_MIN);
		return v;
	endfunction

	function automatic int unsigned spacing_in_use();
		return (cfg_spacing < MIN_SPACING) ? int'(MIN_SPACING) : cfg_spacing;
	endfunction

	// Clamp one coordinate to the extent, divide by the spacing, split into cells and fraction
	function automatic cell_split_t split_axis(longint pos, int unsigned side, int unsigned cs);
		cell_split_t        r;
		longint             ext;
		u64_t               g;
		u64_t               c;
		ext = longint'(side - 1) * longint'(cs);
		if (pos < 0)
			pos = 0;
		if (pos > ext)
			pos = ext;
		g = (u64_t'(pos) << 16) / u64_t'(cs);
		c = g >> 16;
		if (c > side - 1)
			c = side - 1;
		r.i0 = 32'(c);
		r.i1 = (c + 1 > side - 1) ? side - 1 : 32'(c + 1);
		r.frac = 32'((g - (c << 16)) & 64'hFFFF);
		return r;
	endfunction

	// a + floor((b - a) * t / 65536)
	function automatic longint blend(longint a, longint b, int unsigned t);
		longint p;
		p = (b - a) * longint'(t);
		return a + (p >>> 16);
	endfunction

	function automatic longint stored_at(int unsigned x, int unsigned z);
		return longint'(shadow_heights[z * GRID_MAX + x]);
	endfunction

	function automatic height_res_t bilinear_height(logic [31:0] px, logic [31:0] pz);
		height_res_t  r;
		int unsigned  gw, gl, cs;
		longint       sx, sz, h0, h1, h;
		cell_split_t  ax, az;
		gw = side_in_use(cfg_width);
		gl = side_in_use(cfg_length);
		cs = spacing_in_use();
		sx = longint'($signed(px));
		sz = longint'($signed(pz));
		r.in_range = sx >= 0 && sz >= 0 && sx <= longint'(gw - 1) * longint'(cs)
			&& sz <= longint'(gl - 1) * longint'(cs);
		ax = split_axis(sx, gw, cs);
		az = split_axis(sz, gl, cs);
		h0 = blend(stored_at(ax.i0, az.i0), stored_at(ax.i1, az.i0), ax.frac);
		h1 = blend(stored_at(ax.i0, az.i1), stored_at(ax.i1, az.i1), ax.frac);
		h = blend(h0, h1, az.frac);
		if (h > 64'sd2147483647)
			h = 64'sd2147483647;
		if (h < -64'sd2147483648)
			h = -64'sd2147483648;
		r.hgt = h[31:0];
		return r;
	endfunction

	function automatic stim_t mk(logic act, logic [7:0] cx, logic [7:0] cz, logic [31:0] hv,
			logic [31:0] px, logic [31:0] pz, bit typed, logic [31:0] th, logic ti);
		stim_t s;
		s.act = act; s.cx = cx; s.cz = cz; s.hv = hv; s.px = px; s.pz = pz;
		s.typed = typed; s.typed_h = th; s.typed_in = ti;
		return s;
	endfunction

	// Fields that the item's kind does not use still get random contents
	function automatic stim_t random_fill(logic act);
		return mk(act, 8'($urandom), 8'($urandom), $urandom, $urandom, $urandom, 0, '0, 1'b0);
	endfunction

	function automatic int draw_wait(bit on);
		return on ? $urandom_range(0, 17) : 0;
	endfunction

	// Offer one item, hold it until the transfer, then advance the shadow
	task automatic send_item(stim_t s);
		int          gap;
		height_res_t r;
		gap = draw_wait(s_idle_on);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= s.act;
		s_tdata  <= {s.pz, s.px, s.hv, s.cz, s.cx};
		do @(posedge clk); while (!s_tready);
		n_sent++;
		if (s.act == ACT_WRITE) begin
			shadow_heights[{s.cz, s.cx}] = s.hv;
			shadow_written[{s.cz, s.cx}] = 1'b1;
		end else if (s.typed) begin
			r.hgt = s.typed_h;
			r.in_range = s.typed_in;
			pending_heights.push_back(r);
		end else begin
			pending_heights.push_back(bilinear_height(s.px, s.pz));
		end
	endtask

	// Fill any corner the query would read that holds no sample yet, then query
	task automatic send_query(logic [31:0] px, logic [31:0] pz);
		cell_split_t ax, az;
		int unsigned xs[2], zs[2];
		stim_t       s;
		ax = split_axis(longint'($signed(px)), side_in_use(cfg_width), spacing_in_use());
		az = split_axis(longint'($signed(pz)), side_in_use(cfg_length), spacing_in_use());
		xs[0] = ax.i0; xs[1] = ax.i1;
		zs[0] = az.i0; zs[1] = az.i1;
		foreach (xs[i])
			foreach (zs[j])
				if (!shadow_written[zs[j] * GRID_MAX + xs[i]]) begin
					s = random_fill(ACT_WRITE);
					s.cx = 8'(xs[i]);
					s.cz = 8'(zs[j]);
					send_item(s);
				end
		s = random_fill(ACT_QUERY);
		s.px = px;
		s.pz = pz;
		send_item(s);
	endtask

	// Setup and access phases, then the bus idles before the next transfer
	task automatic apb_write(logic [1:0] idx, logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_GRID_WIDTH:   cfg_width   = v[8:0];
			REG_GRID_LENGTH:  cfg_length  = v[8:0];
			REG_CELL_SPACING: cfg_spacing = v[30:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Hold the input idle until every pending result is out, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_heights.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Position along one axis: mostly inside the extent, with edges, grid lines and noise
	function automatic logic [31:0] pick_pos(int unsigned side, int unsigned cs);
		longint          ext, lim;
		u64_t            r64;
		ext = longint'(side - 1) * longint'(cs);
		lim = (ext > 64'sd2147483647) ? 64'sd2147483647 : ext;
		r64 = {$urandom, $urandom};
		case ($urandom_range(0, 11))
			0, 1: return $urandom;
			2:    return 32'd0;
			3:    return lim[31:0];
			4:    return (lim < 64'sd2147483647) ? 32'(lim + 1) : 32'hFFFF_FFFF;
			5: begin
				lim = longint'($urandom_range(0, side - 1)) * longint'(cs);
				return (lim > 64'sd2147483647) ? 32'h7FFF_FFFF : lim[31:0];
			end
			default: return 32'(r64 % u64_t'(lim + 1));
		endcase
	endfunction

	// Send n_items items, corner fills included, at one set of register values
	task automatic run_phase(logic [31:0] w, logic [31:0] l, logic [31:0] cs, int n_items);
		stim_t s;
		int    stop;
		drain();
		apb_write(REG_GRID_WIDTH, w);
		apb_write(REG_GRID_LENGTH, l);
		apb_write(REG_CELL_SPACING, cs);
		apb_write(REG_UNUSED, $urandom);
		s_idle_on = $urandom_range(0, 2) != 0;
		m_idle_on = $urandom_range(0, 2) != 0;
		stop = n_sent + n_items;
		while (n_sent < stop) begin
			if ($urandom_range(0, 99) < 20) begin
				s = random_fill(ACT_WRITE);
				if ($urandom_range(0, 1)) begin
					s.cx = 8'($urandom_range(0, side_in_use(cfg_width) - 1));
					s.cz = 8'($urandom_range(0, side_in_use(cfg_length) - 1));
				end
				case ($urandom_range(0, 7))
					0: s.hv = 32'h7FFF_FFFF;
					1: s.hv = 32'h8000_0000;
					default: ;
				endcase
				send_item(s);
			end else begin
				send_query(pick_pos(side_in_use(cfg_width), spacing_in_use()),
					pick_pos(side_in_use(cfg_length), spacing_in_use()));
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abandon the run if it runs past the cycle limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Result side: stall at random, compare each transfer with the oldest expectation
	initial begin
		int          hold;
		height_res_t want;
		hold = 0;
		forever begin
			@(posedge clk);
			if (!arst_n)
				continue;
			if (m_tvalid && m_tready) begin
				if (pending_heights.size() == 0) begin
					$error("result with no query pending: height %h inside_res %b",
						m_tdata, m_tuser[0]);
					n_fail++;
				end else begin
					want = pending_heights.pop_front();
					if (m_tdata !== want.hgt) begin
						$error("height: expected %h, got %h", want.hgt, m_tdata);
						n_fail++;
					end
					if (m_tuser[0] !== want.in_range) begin
						$error("inside_res: expected %b, got %b", want.in_range, m_tuser[0]);
						n_fail++;
					end
				end
				hold = draw_wait(m_idle_on);
				if (hold > 0)
					m_tready <= 1'b0;
			end else if (!m_tready) begin
				if (hold > 0)
					hold--;
				if (hold == 0)
					m_tready <= 1'b1;
			end
		end
	end

	initial begin
		stim_t directed_rows[$];
		n_fail      = 0;
		n_sent      = 0;
		s_idle_on   = 1'b1;
		m_idle_on   = 1'b1;
		cfg_width   = GRID_WIDTH_RST;
		cfg_length  = GRID_LENGTH_RST;
		cfg_spacing = CELL_SPACING_RST;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings: 256 x 256 samples, 1 m apart.
		// Height extremes at the origin cell, then queries at the corners of the world.
		directed_rows.push_back(mk(ACT_WRITE, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk(ACT_WRITE, 1, 0, 32'h8000_0000, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk(ACT_WRITE, 0, 1, 32'h0000_0000, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk(ACT_WRITE, 1, 1, 32'h0001_0000, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 32'h0, 32'h0, 1, 32'h7FFF_FFFF, 1));
		// negative position clamps to the origin and reads as outside
		directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1, 32'h7FFF_FFFF, 0));
		directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 32'h8000_0000, 32'h8000_0000,
			1, 32'h7FFF_FFFF, 0));
		// blending the two extremes: leave it to the predictor
		directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 32'h0000_8000, 32'h0, 0, 0, 0));
		directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 32'h0000_4000, 32'h0000_C000, 0, 0, 0));
		directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 32'h0000_FFFF, 32'h0000_FFFF, 0, 0, 0));
		// far X edge: neighbour index clamps to the last sample
		directed_rows.push_back(mk(ACT_WRITE, 255, 0, 32'h0005_0000, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk(ACT_WRITE, 255, 1, 32'h0005_0000, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 32'h7FFF_FFFF, 32'h0, 1, 32'h0005_0000, 0));
		directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 32'h00FF_0000, 32'h0, 1, 32'h0005_0000, 1));
		// far Z edge
		directed_rows.push_back(mk(ACT_WRITE, 0, 255, 32'hFFFF_0000, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk(ACT_WRITE, 1, 255, 32'hFFFF_0000, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 32'h0, 32'h7FFF_FFFF, 1, 32'hFFFF_0000, 0));
		// last cell on both axes, beyond and exactly on the extent
		directed_rows.push_back(mk(ACT_WRITE, 255, 255, 32'h1234_5678, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			1, 32'h1234_5678, 0));
		directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 32'h00FF_0000, 32'h00FF_0000,
			1, 32'h1234_5678, 1));
		// overwrite a corner and query straight after it
		directed_rows.push_back(mk(ACT_WRITE, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
		directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 32'h0000_2000, 32'h0000_E000, 0, 0, 0));
		foreach (directed_rows[i])
			send_item(directed_rows[i]);

		// Settings: smallest grid and spacing, sides below two and spacing below the minimum,
		// oversized sides and widest spacing, reset values, a 3 x 17 grid, then a few random mixes
		run_phase(32'd2, 32'd2, 32'd66, 40);
		run_phase(32'd0, 32'd1, 32'd0, 30);
		run_phase(32'h0000_01FF, 32'hFFFF_FF2C, 32'hFFFF_FFFF, 40);
		run_phase(32'd256, 32'd256, 32'd65536, 50);
		run_phase(32'd3, 32'd17, 32'd66, 40);
		repeat (5) begin
			case ($urandom_range(0, 2))
				0: run_phase($urandom_range(2, 24), $urandom_range(2, 24),
					$urandom_range(66, 400), 50);
				1: run_phase($urandom_range(2, 24), $urandom_range(2, 256),
					$urandom_range(32'h8000, 32'h4_0000), 50);
				default: run_phase($urandom_range(2, 256), $urandom_range(2, 24),
					$urandom, 50);
			endcase
		end

		drain();
		if (n_fail == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
design/hbs_pkg.sv
design/hbs_ram.sv
design/hbs_lerp.sv
design/hbs_axis.sv
design/heightmap_bilinear_sampler_core.sv
dv/tb.sv
